// ===== hdl/pdl_pkg.sv =====
// Package for the positional duplicate list core.
// Holds sizes, operation and status codes, payload, command and state types.
// No dependencies.
package pdl_pkg;

   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 6;
   localparam int RCNT_W = 7;
   localparam int EXT_W = 7;
   localparam int RID_W = 64;
   localparam int FLG_W = 8;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_OVERWRITE = 3'd1;
   localparam logic [2:0] MODE_ERASE = 3'd2;
   localparam logic [2:0] MODE_ERASE_ALL = 3'd3;
   localparam logic [2:0] MODE_GET = 3'd4;
   localparam logic [2:0] MODE_GET_COUNT = 3'd5;

   localparam logic [1:0] WHERE_BEFORE = 2'd0;
   localparam logic [1:0] WHERE_AFTER = 2'd1;
   localparam logic [1:0] WHERE_FIRST = 2'd2;
   localparam logic [1:0] WHERE_LAST = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]       mode;
      logic [1:0]       insert_where;
      logic [POS_W-1:0] position;
      logic [RID_W-1:0] entry_rid;
      logic [FLG_W-1:0] entry_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [POS_W-1:0]  result_position;
      logic [RCNT_W-1:0] result_count;
      logic [RID_W-1:0]  result_rid;
      logic [FLG_W-1:0]  result_flags;
      logic              release_valid;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [RID_W-1:0] rid;
      logic [FLG_W-1:0] flags;
   } entry_type;

   typedef struct packed {
      logic cap_req;
      logic exec;
      logic dump_start;
      logic dump_next;
   } cmd_type;

   typedef struct packed {
      logic dump_op;
      logic dump_last;
   } sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP,
      ST_DUMP
   } state_type;

endpackage

// ===== hdl/pdl_ctrl.sv =====
// Controller for the positional duplicate list core.
// Sequences capture, execute and response handshakes. Depends on pdl_pkg.
module pdl_ctrl
   import pdl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.dump_op) begin
               cmd.dump_start = 1'b1;
               state_in = ST_DUMP;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dump_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/pdl_dpath.sv =====
// Datapath for the positional duplicate list core: shifting entry cells,
// count, inline mask, request and response registers. Depends on pdl_pkg.
module pdl_dpath
   import pdl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [FLG_W-1:0] csr_wr_data,
   input  cmd_type          cmd,
   output sts_type          sts
);

   entry_type        cells_ff [DEPTH];
   entry_type        cells_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [FLG_W-1:0] mask_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [CNT_W-1:0] dump_idx_ff, dump_idx_in;
   logic [CNT_W-1:0] dump_n_ff, dump_n_in;

   logic [EXT_W-1:0] pos_ext;
   logic [EXT_W-1:0] cnt_ext;
   logic [EXT_W-1:0] pos_p1;
   logic [EXT_W-1:0] tgt;
   logic [IDX_W-1:0] cnt_m1;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   entry_type        new_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mask_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rsp_ff <= rsp_in;
      dump_idx_ff <= dump_idx_in;
      dump_n_ff <= dump_n_in;
      if (cmd.cap_req) begin
         req_ff <= req_payload;
      end
   end

   assign rsp_payload = rsp_ff;

   always_comb begin
      pos_ext = EXT_W'(req_ff.position);
      cnt_ext = EXT_W'(count_ff);
      pos_p1 = pos_ext + EXT_W'(1);
      cnt_m1 = IDX_W'(count_ff - CNT_W'(1));
      rd_addr = (req_ff.mode == MODE_GET_COUNT) ? cnt_m1 : req_ff.position[IDX_W-1:0];
      rd_entry = cells_ff[rd_addr];
      new_entry.rid = req_ff.entry_rid;
      new_entry.flags = req_ff.entry_flags;
      unique case (req_ff.insert_where)
         WHERE_BEFORE: tgt = pos_ext;
         WHERE_AFTER:  tgt = (pos_p1 > cnt_ext) ? cnt_ext : pos_p1;
         WHERE_FIRST:  tgt = '0;
         WHERE_LAST:   tgt = cnt_ext;
         default:      tgt = '0;
      endcase
   end

   assign sts.dump_op = (req_ff.mode == MODE_ERASE_ALL) && (count_ff != '0);
   assign sts.dump_last = (dump_idx_ff + CNT_W'(1)) == dump_n_ff;

   always_comb begin
      cells_in = cells_ff;
      count_in = count_ff;
      rsp_in = rsp_ff;
      dump_idx_in = dump_idx_ff;
      dump_n_in = dump_n_ff;

      if (cmd.exec) begin
         rsp_in = '0;
         rsp_in.last = 1'b1;
         rsp_in.result_count = RCNT_W'(count_ff);
         unique case (req_ff.mode)
            MODE_INSERT: begin
               if (cnt_ext == EXT_W'(DEPTH)) begin
                  rsp_in.status = STATUS_FULL;
               end else if (req_ff.insert_where == WHERE_BEFORE && pos_ext > cnt_ext) begin
                  rsp_in.status = STATUS_RANGE;
               end else begin
                  for (int i = 1; i < DEPTH; i++) begin
                     if (EXT_W'(i) > tgt) begin
                        cells_in[i] = cells_ff[i-1];
                     end
                  end
                  cells_in[tgt[IDX_W-1:0]] = new_entry;
                  count_in = count_ff + CNT_W'(1);
                  rsp_in.result_position = POS_W'(tgt);
                  rsp_in.result_count = RCNT_W'(count_ff) + RCNT_W'(1);
               end
            end
            MODE_OVERWRITE, MODE_ERASE: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_in.status = STATUS_RANGE;
               end else begin
                  rsp_in.result_position = req_ff.position;
                  rsp_in.result_rid = rd_entry.rid;
                  rsp_in.result_flags = rd_entry.flags;
                  rsp_in.release_valid = (rd_entry.flags & mask_ff) == '0;
                  if (req_ff.mode == MODE_OVERWRITE) begin
                     cells_in[rd_addr] = new_entry;
                  end else begin
                     for (int i = 0; i < DEPTH - 1; i++) begin
                        if (EXT_W'(i) >= pos_ext) begin
                           cells_in[i] = cells_ff[i+1];
                        end
                     end
                     count_in = count_ff - CNT_W'(1);
                     rsp_in.result_count = RCNT_W'(count_ff) - RCNT_W'(1);
                  end
               end
            end
            MODE_GET: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_in.status = STATUS_RANGE;
               end else begin
                  rsp_in.result_position = req_ff.position;
                  rsp_in.result_rid = rd_entry.rid;
                  rsp_in.result_flags = rd_entry.flags;
               end
            end
            MODE_GET_COUNT: begin
               if (count_ff != '0) begin
                  rsp_in.result_position = POS_W'(cnt_m1);
                  rsp_in.result_rid = rd_entry.rid;
                  rsp_in.result_flags = rd_entry.flags;
               end
            end
            default: begin
               // erase all on an empty list and unused codes: status and count only
            end
         endcase
      end

      if (cmd.dump_start) begin
         dump_idx_in = '0;
         dump_n_in = count_ff;
         count_in = '0;
         rsp_in = '0;
         rsp_in.result_rid = cells_ff[0].rid;
         rsp_in.result_flags = cells_ff[0].flags;
         rsp_in.release_valid = (cells_ff[0].flags & mask_ff) == '0;
         rsp_in.last = count_ff == CNT_W'(1);
      end

      if (cmd.dump_next) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            cells_in[i] = cells_ff[i+1];
         end
         dump_idx_in = dump_idx_ff + CNT_W'(1);
         rsp_in = '0;
         rsp_in.result_position = POS_W'(dump_idx_ff + CNT_W'(1));
         rsp_in.result_rid = cells_ff[1].rid;
         rsp_in.result_flags = cells_ff[1].flags;
         rsp_in.release_valid = (cells_ff[1].flags & mask_ff) == '0;
         rsp_in.last = (EXT_W'(dump_idx_ff) + EXT_W'(2)) == EXT_W'(dump_n_ff);
      end
   end

endmodule

// ===== hdl/positional_duplicate_list_core.sv =====
// Top level of the positional duplicate list core.
// Instantiates pdl_ctrl and pdl_dpath; depends on pdl_pkg.
//
//   channel   ports                           direction
//   request   req_valid/req_stall/req_payload  in  (stall driven here)
//   response  rsp_valid/rsp_stall/rsp_payload  out (stall driven by sink)
//   csr       csr_wr_en/csr_wr_data            in  (inline_mask, no read-back)
//
// A request passes through three steps: capture, execute (one pass
// through the shifting cell array) and response.
// Erase all on n entries gives one response per entry, in list order,
// while the cells shift down one place.
// Reset is synchronous: the list is emptied and inline_mask cleared.
// A stalled response holds the core; req_stall stays high until it is taken.
module positional_duplicate_list_core
   import pdl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [FLG_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: which step runs each cycle
   pdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry cells, count, mask and the request/response registers
   pdl_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== tb/pdl_list_checker.sv =====
`timescale 1ns / 100ps
// Checker for positional_duplicate_list_core: watches the request, response and
// csr ports, keeps its own copy of the entry list and compares every response.
// Depends on pdl_pkg.
module pdl_list_checker
   import pdl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [FLG_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_rsp,
   output int               list_size
);

   entry_type        shadow_list [DEPTH];
   int               shadow_count;
   logic [FLG_W-1:0] shadow_mask;
   rsp_type          due_rsp [$];

   function automatic rsp_type make_rsp(input logic [1:0] status, input int pos,
                                        input int cnt, input entry_type ent,
                                        input logic rel, input logic fin);
      rsp_type r;
      r.status          = status;
      r.result_position = POS_W'(pos);
      r.result_count    = RCNT_W'(cnt);
      r.result_rid      = ent.rid;
      r.result_flags    = ent.flags;
      r.release_valid   = rel;
      r.last            = fin;
      return r;
   endfunction

   function automatic logic needs_free(input logic [FLG_W-1:0] f);
      return (f & shadow_mask) == '0;
   endfunction

   // Applies one request to the shadow list and queues the responses it causes.
   task automatic apply_list_op(input req_type r);
      int        tgt;
      int        n;
      int        i;
      int        pos;
      entry_type old;
      entry_type blank;
      blank = '0;
      pos   = int'(r.position);
      case (r.mode)
         MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               due_rsp.push_back(make_rsp(STATUS_FULL, 0, shadow_count, blank,
                                          1'b0, 1'b1));
            end else if (r.insert_where == WHERE_BEFORE && pos > shadow_count) begin
               due_rsp.push_back(make_rsp(STATUS_RANGE, 0, shadow_count, blank,
                                          1'b0, 1'b1));
            end else begin
               case (r.insert_where)
                  WHERE_BEFORE: tgt = pos;
                  WHERE_AFTER: begin
                     tgt = pos + 1;
                     if (tgt > shadow_count) tgt = shadow_count;
                  end
                  WHERE_FIRST: tgt = 0;
                  default: tgt = shadow_count;
               endcase
               for (i = shadow_count; i > tgt; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[tgt].rid   = r.entry_rid;
               shadow_list[tgt].flags = r.entry_flags;
               shadow_count++;
               due_rsp.push_back(make_rsp(STATUS_OK, tgt, shadow_count, blank,
                                          1'b0, 1'b1));
            end
         end
         MODE_OVERWRITE, MODE_ERASE: begin
            if (pos >= shadow_count) begin
               due_rsp.push_back(make_rsp(STATUS_RANGE, 0, shadow_count, blank,
                                          1'b0, 1'b1));
            end else begin
               old = shadow_list[r.position[IDX_W-1:0]];
               if (r.mode == MODE_OVERWRITE) begin
                  shadow_list[r.position[IDX_W-1:0]].rid   = r.entry_rid;
                  shadow_list[r.position[IDX_W-1:0]].flags = r.entry_flags;
               end else begin
                  for (i = pos; i + 1 < shadow_count; i++)
                     shadow_list[i] = shadow_list[i+1];
                  shadow_count--;
               end
               due_rsp.push_back(make_rsp(STATUS_OK, pos, shadow_count, old,
                                          needs_free(old.flags), 1'b1));
            end
         end
         MODE_ERASE_ALL: begin
            n = shadow_count;
            shadow_count = 0;
            if (n == 0) due_rsp.push_back(make_rsp(STATUS_OK, 0, 0, blank, 1'b0, 1'b1));
            for (i = 0; i < n; i++)
               due_rsp.push_back(make_rsp(STATUS_OK, i, 0, shadow_list[i],
                                          needs_free(shadow_list[i].flags), i + 1 == n));
         end
         MODE_GET: begin
            if (pos >= shadow_count)
               due_rsp.push_back(make_rsp(STATUS_RANGE, 0, shadow_count, blank,
                                          1'b0, 1'b1));
            else
               due_rsp.push_back(make_rsp(STATUS_OK, pos, shadow_count,
                                          shadow_list[r.position[IDX_W-1:0]],
                                          1'b0, 1'b1));
         end
         MODE_GET_COUNT: begin
            if (shadow_count == 0)
               due_rsp.push_back(make_rsp(STATUS_OK, 0, 0, blank, 1'b0, 1'b1));
            else
               due_rsp.push_back(make_rsp(STATUS_OK, shadow_count - 1, shadow_count,
                                          shadow_list[shadow_count-1], 1'b0, 1'b1));
         end
         // spare codes: no-op, reports the count
         default: due_rsp.push_back(make_rsp(STATUS_OK, 0, shadow_count, blank,
                                             1'b0, 1'b1));
      endcase
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (due_rsp.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: response with none due: st=%0d pos=%0d cnt=%0d rid=%h fl=%h",
                     $realtime, got.status, got.result_position, got.result_count,
                     got.result_rid, got.result_flags);
         return;
      end
      want = due_rsp.pop_front();
      if (got.status !== want.status || got.result_position !== want.result_position ||
          got.result_count !== want.result_count || got.result_rid !== want.result_rid ||
          got.result_flags !== want.result_flags ||
          got.release_valid !== want.release_valid || got.last !== want.last) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: response mismatch", $realtime);
            $display("  exp st=%0d pos=%0d cnt=%0d rid=%h fl=%h rel=%b last=%b",
                     want.status, want.result_position, want.result_count,
                     want.result_rid, want.result_flags, want.release_valid, want.last);
            $display("  got st=%0d pos=%0d cnt=%0d rid=%h fl=%h rel=%b last=%b",
                     got.status, got.result_position, got.result_count,
                     got.result_rid, got.result_flags, got.release_valid, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         shadow_mask  = '0;
         fail_count   = 0;
         due_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_rsp(rsp_payload);
         if (csr_wr_en) shadow_mask = csr_wr_data;
         if (req_valid && !req_stall) apply_list_op(req_payload);
      end
      pending_rsp = due_rsp.size();
      list_size   = shadow_count;
   end

endmodule

// ===== tb/tb_positional_duplicate_list_core.sv =====
`timescale 1ns / 100ps
// Testbench top for positional_duplicate_list_core: makes requests, csr writes
// and response back-pressure, and gives the verdict from pdl_list_checker.
// Depends on pdl_pkg, the core and tb/pdl_list_checker.sv.
module tb_positional_duplicate_list_core;
   import pdl_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   // long sink hold-off, enough for the core to back up and stall requests
   localparam int LONG_HOLD   = 300;
   // spare mode codes, expected to act as a no-op
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_payload;
   logic             csr_wr_en;
   logic [FLG_W-1:0] csr_wr_data;

   int fail_count;
   int pending_rsp;
   int list_size;

   bit sink_hold_req = 1'b0;   // set by the stimulus, cleared by the sink
   bit sender_quiet  = 1'b0;   // back-to-back requests while set

   positional_duplicate_list_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pdl_list_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending_rsp (pending_rsp),
      .list_size   (list_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hang guard
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [RID_W-1:0] rand_rid();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [FLG_W-1:0] rand_flags();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return FLG_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type mk_req(input logic [2:0] mode, input logic [1:0] where,
                                      input int pos, input logic [RID_W-1:0] rid,
                                      input logic [FLG_W-1:0] flags);
      req_type r;
      r.mode         = mode;
      r.insert_where = where;
      r.position     = POS_W'(pos);
      r.entry_rid    = rid;
      r.entry_flags  = flags;
      return r;
   endfunction

   // Random request aimed mostly at valid positions of the current list;
   // one in ten uses a fully random position. bias = percent of inserts.
   function automatic req_type make_request(input int bias);
      req_type r;
      int      p;
      int      cnt;
      cnt            = list_size;
      r.insert_where = 2'($urandom_range(0, 3));
      r.entry_rid    = rand_rid();
      r.entry_flags  = rand_flags();
      p = $urandom_range(0, 99);
      if (p < bias) begin
         r.mode = MODE_INSERT;
      end else begin
         p = $urandom_range(0, 99);
         if (p < 20) r.mode = MODE_OVERWRITE;
         else if (p < 45) r.mode = MODE_ERASE;
         else if (p < 50) r.mode = MODE_ERASE_ALL;
         else if (p < 75) r.mode = MODE_GET;
         else if (p < 95) r.mode = MODE_GET_COUNT;
         else r.mode = p[0] ? MODE_SPARE_7 : MODE_SPARE_6;
      end
      if ($urandom_range(0, 9) == 0) r.position = POS_W'($urandom);
      else if (r.mode == MODE_INSERT) r.position = POS_W'($urandom_range(0, cnt));
      else if (cnt > 0) r.position = POS_W'($urandom_range(0, cnt - 1));
      else r.position = '0;
      return r;
   endfunction

   // Offers one request and returns at the edge where it is taken.
   // valid stays high; the caller drops it when a gap follows.
   task automatic send_req(input req_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_and_idle(input req_type r);
      send_req(r);
      sender_gap();
   endtask

   // Stop offering and wait until every due response is in.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(input logic [FLG_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int n, input int bias);
      for (int k = 0; k < n; k++) begin
         if (k % 20 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         send_and_idle(make_request(bias));
      end
      sender_quiet = 1'b0;
   endtask

   // Response sink: random stalls, quiet stretches, and one long hold-off
   // on request while the sender keeps offering.
   initial begin : rsp_sink
      int stall_left;
      int quiet_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      quiet_left = 0;
      forever begin
         @(posedge clock);
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(30, 80);
            else if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: low nibble marks inline entries
      write_mask(8'h0F);
      // empty list: count, erase all, out-of-range accesses
      send_and_idle(mk_req(MODE_GET_COUNT, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_ERASE_ALL, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_GET, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_ERASE, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_OVERWRITE, WHERE_BEFORE, 63, '1, '1));
      send_and_idle(mk_req(MODE_INSERT, WHERE_BEFORE, 1, '1, '1));
      // every placement; insert after 63 clamps to the end
      send_and_idle(mk_req(MODE_INSERT, WHERE_BEFORE, 0, '1, 8'hFF));
      send_and_idle(mk_req(MODE_INSERT, WHERE_AFTER, 63, '0, 8'h00));
      send_and_idle(mk_req(MODE_INSERT, WHERE_FIRST, 0, rand_rid(), 8'h10));
      send_and_idle(mk_req(MODE_INSERT, WHERE_LAST, 0, rand_rid(), 8'h01));
      send_and_idle(mk_req(MODE_INSERT, WHERE_BEFORE, 2, rand_rid(), 8'hA5));
      send_and_idle(mk_req(MODE_INSERT, WHERE_AFTER, 0, rand_rid(), 8'h5A));
      send_and_idle(mk_req(MODE_GET, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_GET, WHERE_BEFORE, 5, '0, '0));
      send_and_idle(mk_req(MODE_GET, WHERE_BEFORE, 6, '0, '0));
      send_and_idle(mk_req(MODE_GET, WHERE_BEFORE, 63, '0, '0));
      // overwrite/erase: one non-inline, one inline victim
      send_and_idle(mk_req(MODE_OVERWRITE, WHERE_BEFORE, 1, rand_rid(), 8'hF0));
      send_and_idle(mk_req(MODE_ERASE, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_ERASE, WHERE_BEFORE, 63, '0, '0));
      send_and_idle(mk_req(MODE_SPARE_6, WHERE_BEFORE, 0, '1, '1));
      send_and_idle(mk_req(MODE_SPARE_7, WHERE_LAST, 63, '1, '1));
      send_and_idle(mk_req(MODE_GET_COUNT, WHERE_BEFORE, 0, '0, '0));
      send_and_idle(mk_req(MODE_ERASE_ALL, WHERE_BEFORE, 0, '0, '0));
      wait_idle();

      // insert-heavy: runs into a full list, then dumps it all at once
      write_mask(8'h00);
      run_random(60, 75);
      send_req(mk_req(MODE_ERASE_ALL, WHERE_BEFORE, 0, '0, '0));
      wait_idle();

      // every flag bit inline; long sink hold-off while requests keep coming
      write_mask(8'hFF);
      sink_hold_req = 1'b1;
      run_random(40, 35);
      wait_idle();

      write_mask(FLG_W'($urandom_range(1, 254)));
      run_random(40, 50);
      wait_idle();

      write_mask(8'h80);
      run_random(40, 45);
      wait_idle();
      repeat (40) @(posedge clock);

      if (fail_count == 0 && pending_rsp == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pdl_pkg.sv
hdl/pdl_ctrl.sv
hdl/pdl_dpath.sv
hdl/positional_duplicate_list_core.sv
tb/pdl_list_checker.sv
tb/tb_positional_duplicate_list_core.sv
